[rtl/core/ptoc_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic task overlap check: shared package
// Operation codes that the sequencer broadcasts to the row of queue cells.
// ----------------------------------------------------------------------------
package ptoc_pkg;

   // Operation applied together by every cell of the sorted task row.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REPLACE,
      CELL_POP,
      CELL_CLEAR
   } cell_op_type;

endpackage

[rtl/core/ptoc_cell.sv]
// ----------------------------------------------------------------------------
// Periodic task overlap check: queue cell
// One slot of the sorted task row. It holds one task and trades it with its
// neighbors so that the row stays sorted on insert, pop and head replacement.
// ----------------------------------------------------------------------------
module ptoc_cell
   import ptoc_pkg::*;
#(
   parameter int ENTRY_W = 98
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_op_type        cell_op,
   input  logic [ENTRY_W-1:0] new_entry,
   input  logic [ENTRY_W-1:0] prev_entry,
   input  logic               prev_valid,
   input  logic               prev_lt,
   input  logic [ENTRY_W-1:0] next_entry,
   input  logic               next_valid,
   input  logic               next_lt,
   output logic [ENTRY_W-1:0] entry_ff,
   output logic               valid_ff,
   output logic               lt
);

   logic [ENTRY_W-1:0] entry_in;
   logic               valid_in;

   // An empty slot ranks after every task.
   assign lt = !valid_ff || (new_entry < entry_ff);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (cell_op)
         CELL_INSERT: begin
            if (prev_lt) begin
               entry_in = prev_entry;
               valid_in = prev_valid;
            end else if (lt) begin
               entry_in = new_entry;
               valid_in = 1'b1;
            end
         end
         CELL_REPLACE: begin
            // The head leaves and the new task drops into its sorted slot.
            if (!lt) begin
               if (next_lt) begin
                  entry_in = new_entry;
                  valid_in = 1'b1;
               end else begin
                  entry_in = next_entry;
                  valid_in = next_valid;
               end
            end
         end
         CELL_POP: begin
            entry_in = next_entry;
            valid_in = next_valid;
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            entry_in = entry_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

[rtl/core/periodic_task_overlap_check.sv]
// ----------------------------------------------------------------------------
// Periodic task overlap check
// Collects periodic tasks in a sorted row of cells and reports whether any
// task starts before the previous one has ended, up to a time horizon.
// ----------------------------------------------------------------------------
// Usage. A command is taken at a rising edge with start high and busy low.
// req_op low loads one task (req_start_time, req_end_time, req_period); the
// load returns nothing. A load into a full row is dropped and remembered as
// an overflow. req_op high evaluates the loaded set: the block pops tasks in
// start order, one pop per cycle, and pushes a periodic task back shifted by
// its period in the same cycle. An evaluation runs while time is inside the
// horizon, tasks remain and no conflict has been seen; the number of pops is
// set by the horizon and the periods, and one pop through the cell row is the
// unit of work. Its single result appears on rsp_conflict and rsp_overflow,
// marked by rsp_strobe for exactly one cycle, and the receiver cannot stall
// it. The row and the overflow flag are emptied with that result. The
// horizon register is written over the csr_ channel, always ready; the
// user is to write it only while the block is idle, as the block itself
// does not enforce this. Synchronous reset empties the row, clears the
// overflow flag and sets the horizon to zero.
// ----------------------------------------------------------------------------
module periodic_task_overlap_check
   import ptoc_pkg::*;
#(
   parameter int HEAP_DEPTH = 256,
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [TIME_WIDTH-1:0] req_start_time,
   input  logic [TIME_WIDTH-1:0] req_end_time,
   input  logic [TIME_WIDTH-1:0] req_period,
   output logic                  rsp_strobe,
   output logic                  rsp_conflict,
   output logic                  rsp_overflow,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TIME_WIDTH-1:0] csr_data
);

   // A stored task is {start, end, period}; start and end carry one extra
   // bit so that shifted times can saturate instead of wrapping. Comparing
   // the packed word orders tasks by start, then end, then period.
   localparam int TW1     = TIME_WIDTH + 1;
   localparam int ENTRY_W = 3 * TIME_WIDTH + 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EVAL
   } state_type;

   state_type             state_ff, state_in;
   logic [TIME_WIDTH-1:0] horizon_ff, horizon_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;
   logic [TIME_WIDTH-1:0] end_ff, end_in;
   logic [TIME_WIDTH-1:0] period_ff, period_in;
   logic [TW1-1:0]        cur_time_ff, cur_time_in;
   logic                  conflict_ff, conflict_in;
   logic                  overflow_ff, overflow_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_conflict_ff, rsp_conflict_in;
   logic                  rsp_overflow_ff, rsp_overflow_in;

   cell_op_type           cell_op;
   logic [ENTRY_W-1:0]    new_entry;

   logic [ENTRY_W-1:0]    entry_row [HEAP_DEPTH];
   logic [HEAP_DEPTH-1:0] valid_row;
   logic [HEAP_DEPTH-1:0] lt_row;

   // Fields of the task at the head of the row.
   logic [TW1-1:0]        head_start;
   logic [TW1-1:0]        head_end;
   logic [TIME_WIDTH-1:0] head_period;
   logic [TW1:0]          start_sum;
   logic [TW1:0]          end_sum;
   logic [TW1-1:0]        next_start;
   logic [TW1-1:0]        next_end;
   logic                  keep_going;

   assign head_start  = entry_row[0][ENTRY_W-1 -: TW1];
   assign head_end    = entry_row[0][TIME_WIDTH +: TW1];
   assign head_period = entry_row[0][TIME_WIDTH-1:0];

   // Shifted repetition of the head task, saturating at all ones.
   assign start_sum  = {1'b0, head_start} + {2'b00, head_period};
   assign end_sum    = {1'b0, head_end} + {2'b00, head_period};
   assign next_start = start_sum[TW1] ? {TW1{1'b1}} : start_sum[TW1-1:0];
   assign next_end   = end_sum[TW1] ? {TW1{1'b1}} : end_sum[TW1-1:0];

   // The evaluation continues while time is inside the horizon, tasks remain
   // and no conflict has been seen.
   assign keep_going = (cur_time_ff <= {1'b0, horizon_ff}) && valid_row[0] && !conflict_ff;

   assign busy         = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_conflict = rsp_conflict_ff;
   assign rsp_overflow = rsp_overflow_ff;

   always_comb begin
      state_in        = state_ff;
      horizon_in      = horizon_ff;
      start_in        = start_ff;
      end_in          = end_ff;
      period_in       = period_ff;
      cur_time_in     = cur_time_ff;
      conflict_in     = conflict_ff;
      overflow_in     = overflow_ff;
      rsp_strobe_in   = 1'b0;
      rsp_conflict_in = rsp_conflict_ff;
      rsp_overflow_in = rsp_overflow_ff;
      cell_op         = CELL_HOLD;
      new_entry       = {next_start, next_end, head_period};

      if (csr_valid && csr_ready) begin
         horizon_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               start_in    = req_start_time;
               end_in      = req_end_time;
               period_in   = req_period;
               cur_time_in = '0;
               conflict_in = 1'b0;
               state_in    = req_op ? ST_EVAL : ST_LOAD;
            end
         end
         ST_LOAD: begin
            new_entry = {1'b0, start_ff, 1'b0, end_ff, period_ff};
            // A full row has its last cell occupied; the task is dropped.
            if (valid_row[HEAP_DEPTH-1]) begin
               overflow_in = 1'b1;
            end else begin
               cell_op = CELL_INSERT;
            end
            state_in = ST_IDLE;
         end
         ST_EVAL: begin
            if (keep_going) begin
               if (head_start < cur_time_ff) begin
                  conflict_in = 1'b1;
               end else begin
                  cur_time_in = head_end;
                  cell_op     = (head_period != '0) ? CELL_REPLACE : CELL_POP;
               end
            end else begin
               rsp_strobe_in   = 1'b1;
               rsp_conflict_in = conflict_ff;
               rsp_overflow_in = overflow_ff;
               overflow_in     = 1'b0;
               cell_op         = CELL_CLEAR;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff        <= start_in;
      end_ff          <= end_in;
      period_ff       <= period_in;
      cur_time_ff     <= cur_time_in;
      rsp_conflict_ff <= rsp_conflict_in;
      rsp_overflow_ff <= rsp_overflow_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         horizon_ff    <= '0;
         conflict_ff   <= 1'b0;
         overflow_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         horizon_ff    <= horizon_in;
         conflict_ff   <= conflict_in;
         overflow_ff   <= overflow_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // The sorted row of cells. Each cell sees its two neighbors; the first
   // cell has no predecessor and the last one sees an empty slot after it.
   for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
      logic [ENTRY_W-1:0] prev_entry;
      logic               prev_valid;
      logic               prev_lt;
      logic [ENTRY_W-1:0] next_entry;
      logic               next_valid;
      logic               next_lt;

      if (i == 0) begin : g_first
         assign prev_entry = '0;
         assign prev_valid = 1'b0;
         assign prev_lt    = 1'b0;
      end else begin : g_inner_prev
         assign prev_entry = entry_row[i-1];
         assign prev_valid = valid_row[i-1];
         assign prev_lt    = lt_row[i-1];
      end

      if (i == HEAP_DEPTH - 1) begin : g_last
         assign next_entry = '0;
         assign next_valid = 1'b0;
         assign next_lt    = 1'b1;
      end else begin : g_inner_next
         assign next_entry = entry_row[i+1];
         assign next_valid = valid_row[i+1];
         assign next_lt    = lt_row[i+1];
      end

      ptoc_cell #(
         .ENTRY_W(ENTRY_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_op   (cell_op),
         .new_entry (new_entry),
         .prev_entry(prev_entry),
         .prev_valid(prev_valid),
         .prev_lt   (prev_lt),
         .next_entry(next_entry),
         .next_valid(next_valid),
         .next_lt   (next_lt),
         .entry_ff  (entry_row[i]),
         .valid_ff  (valid_row[i]),
         .lt        (lt_row[i])
      );
   end

`ifndef SYNTH
   // Occupied cells always form an unbroken run from the head.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (((valid_row >> 1) & ~valid_row) == '0))
      else $error("occupied cells are not contiguous from the head");

   // The head never ranks after its neighbor.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      valid_row[1] |-> !(entry_row[1] < entry_row[0]))
      else $error("head task ranks after the second task");

   // The result strobe is high for a single cycle only.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // The row and the overflow flag are empty once a result is out.
   a_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!valid_row[0] && !overflow_ff && !busy))
      else $error("task row not emptied with the result");
`endif

endmodule

[tb/sv/periodic_task_overlap_check_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task overlap check: self-checking testbench
// Loads task sets and evaluates them against several horizon settings,
// predicts each verdict with an independent min-heap schedule walker and
// compares every result transfer with the oldest pending prediction.
// ----------------------------------------------------------------------------

typedef enum bit {
   OP_LOAD,
   OP_EVALUATE
} command_op_type;

// Keeps its own copy of the task heap, the overflow flag and the horizon,
// and stores the verdicts that the block still owes.
class task_schedule_scoreboard;
   localparam int unsigned SLOTS = 256;
   localparam bit [32:0] TIME_CEILING = '1;

   typedef struct packed {
      bit [32:0] begin_at;
      bit [32:0] finish_at;
      bit [31:0] every;
   } slot_type;

   typedef struct packed {
      bit conflict;
      bit overflow;
   } verdict_type;

   slot_type    slots[SLOTS];
   int unsigned filled;
   bit          dropped;
   bit [31:0]   horizon;
   verdict_type verdicts_due[$];
   int unsigned fault_count;
   int unsigned evaluations;
   int unsigned conflicts;
   int unsigned overflows;
   int unsigned pops;

   // Heap order: earlier start, then earlier end, then shorter period.
   function bit precedes(slot_type a, slot_type b);
      if (a.begin_at != b.begin_at) return a.begin_at < b.begin_at;
      if (a.finish_at != b.finish_at) return a.finish_at < b.finish_at;
      return a.every < b.every;
   endfunction

   function bit push_slot(slot_type item);
      int unsigned k;
      int unsigned up;
      slot_type    tmp;
      if (filled >= SLOTS) return 1'b0;
      k = filled;
      filled++;
      slots[k] = item;
      while (k > 0) begin
         up = (k - 1) / 2;
         if (!precedes(slots[k], slots[up])) break;
         tmp = slots[k];
         slots[k] = slots[up];
         slots[up] = tmp;
         k = up;
      end
      return 1'b1;
   endfunction

   function slot_type pop_slot();
      int unsigned k;
      int unsigned l;
      int unsigned r;
      int unsigned m;
      slot_type    top;
      slot_type    tmp;
      top = slots[0];
      filled--;
      if (filled == 0) return top;
      slots[0] = slots[filled];
      k = 0;
      forever begin
         l = 2 * k + 1;
         r = l + 1;
         m = k;
         if (l < filled && precedes(slots[l], slots[m])) m = l;
         if (r < filled && precedes(slots[r], slots[m])) m = r;
         if (m == k) break;
         tmp = slots[k];
         slots[k] = slots[m];
         slots[m] = tmp;
         k = m;
      end
      return top;
   endfunction

   // Shifted times live in one extra bit and stick at the all-ones value.
   function bit [32:0] shift_time(bit [32:0] t, bit [31:0] p);
      bit [33:0] sum;
      sum = {1'b0, t} + {2'b00, p};
      return (sum > {1'b0, TIME_CEILING}) ? TIME_CEILING : sum[32:0];
   endfunction

   function void set_horizon(bit [31:0] value);
      horizon = value;
   endfunction

   // Called for every accepted command transfer.
   function void note_command(command_op_type op, bit [31:0] s, bit [31:0] e, bit [31:0] p);
      slot_type    item;
      slot_type    again;
      verdict_type verdict;
      bit [32:0]   now;
      bit          clash;
      if (op == OP_LOAD) begin
         item.begin_at = {1'b0, s};
         item.finish_at = {1'b0, e};
         item.every = p;
         if (!push_slot(item)) dropped = 1'b1;
         return;
      end
      now = '0;
      clash = 1'b0;
      while (now <= {1'b0, horizon} && filled > 0 && !clash) begin
         item = pop_slot();
         pops++;
         if (item.begin_at < now) begin
            clash = 1'b1;
         end else begin
            now = item.finish_at;
            if (item.every != 0) begin
               again.begin_at = shift_time(item.begin_at, item.every);
               again.finish_at = shift_time(item.finish_at, item.every);
               again.every = item.every;
               void'(push_slot(again));
            end
         end
      end
      verdict.conflict = clash;
      verdict.overflow = dropped;
      verdicts_due.push_back(verdict);
      evaluations++;
      if (clash) conflicts++;
      if (dropped) overflows++;
      filled = 0;
      dropped = 1'b0;
   endfunction

   // Called for every result transfer.
   function void check_verdict(logic conflict, logic overflow);
      verdict_type want;
      if (verdicts_due.size() == 0) begin
         $error("result transfer with no evaluation pending: conflict %b, overflow %b",
                conflict, overflow);
         fault_count++;
         return;
      end
      want = verdicts_due.pop_front();
      if (conflict !== want.conflict) begin
         $error("rsp_conflict mismatch: expected %0b, actual %b", want.conflict, conflict);
         fault_count++;
      end
      if (overflow !== want.overflow) begin
         $error("rsp_overflow mismatch: expected %0b, actual %b", want.overflow, overflow);
         fault_count++;
      end
   endfunction
endclass

module periodic_task_overlap_check_test;

   localparam int TIME_W = 32;
   localparam int HEAP_SLOTS = 256;
   // Cycles allowed after the last verdict for a trailing load to drain.
   localparam int SETTLE_CYCLES = 8;
   // About 2100 commands: loads and sender gaps take time, and the
   // evaluations pop at most roughly 33 times per loaded task because every
   // nonzero random period is kept at or above a 32nd of the horizon. The
   // limit is set well above the slowest correct run, leaving a wide margin.
   localparam int unsigned CLOCK_LIMIT = 2_000_000;
   localparam int PHASES = 6;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_op;
   logic [TIME_W-1:0] req_start_time;
   logic [TIME_W-1:0] req_end_time;
   logic [TIME_W-1:0] req_period;
   logic              rsp_strobe;
   logic              rsp_conflict;
   logic              rsp_overflow;
   logic              csr_valid;
   logic              csr_ready;
   logic [TIME_W-1:0] csr_data;

   task_schedule_scoreboard book;
   int unsigned             sender_idle_pct = 0;
   int unsigned             items_sent = 0;
   int unsigned             cycle_count = 0;

   periodic_task_overlap_check #(
      .HEAP_DEPTH (HEAP_SLOTS),
      .TIME_WIDTH (TIME_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .req_period     (req_period),
      .rsp_strobe     (rsp_strobe),
      .rsp_conflict   (rsp_conflict),
      .rsp_overflow   (rsp_overflow),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   // The watchdog ends a run that hangs, for instance on a lost result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CLOCK_LIMIT) begin
         $display("periodic_task_overlap_check_test failed");
         $finish;
      end
   end

   // The block cannot be stalled on its result side, so every strobe is a
   // result transfer and is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         book.check_verdict(rsp_conflict, rsp_overflow);
      end
   end

   // Smallest period that keeps an evaluation within about 33 pops per task
   // at the current horizon.
   function automatic bit [31:0] period_floor();
      return (book.horizon >> 5) + 1;
   endfunction

   // Presents one command and returns at the edge where it is accepted. Start
   // is left high so that a following command can go out back to back; a gap
   // lowers it only in a later time step.
   task automatic send_command(command_op_type op, bit [31:0] s, bit [31:0] e, bit [31:0] p);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_start_time <= s;
      req_end_time <= e;
      req_period <= p;
      do @(posedge clock); while (busy !== 1'b0);
      book.note_command(op, s, e, p);
      items_sent++;
   endtask

   task automatic write_horizon(bit [31:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      book.set_horizon(value);
      csr_valid <= 1'b0;
   endtask

   // Brings the block to idle: every verdict back, then a short pause in case
   // a load is still being sorted in.
   task automatic settle();
      start <= 1'b0;
      while (book.verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Loads a well-formed schedule: tasks sit in disjoint slots of one frame
   // and repeat every frame, every other frame or never, so the walk runs far
   // into the horizon without a conflict. Sometimes one task is spoiled,
   // either by starting it a little early or by giving it a period one short
   // of the frame, which makes it drift into its neighbor after many pops.
   // The load order is shuffled so the heap sees arbitrary insert orders.
   task automatic load_schedule(int unsigned count, bit close_it);
      bit [31:0]   cuts[$];
      bit [31:0]   starts[$];
      bit [31:0]   ends[$];
      bit [31:0]   periods[$];
      bit [31:0]   lo;
      bit [31:0]   frame;
      bit [31:0]   base;
      bit [31:0]   tmp;
      int unsigned pick;
      int unsigned j;
      int          i;
      lo = period_floor();
      if (lo < 4 * count) lo = 4 * count;
      frame = $urandom_range(lo, lo * 4);
      base = $urandom_range(0, 1) ? $urandom_range(0, 32'h7FFF_FFFF) : $urandom_range(0, 16);
      for (i = 0; i < 2 * count; i++) cuts.push_back($urandom_range(0, frame));
      cuts.sort();
      for (i = 0; i < count; i++) begin
         starts.push_back(base + cuts[2 * i]);
         ends.push_back(base + cuts[2 * i + 1]);
         pick = $urandom_range(0, 9);
         periods.push_back(pick < 5 ? frame : (pick < 8 ? 32'd0 : 2 * frame));
      end
      j = $urandom_range(0, count - 1);
      case ($urandom_range(0, 3))
         1: begin
            tmp = $urandom_range(1, 3);
            starts[j] = (starts[j] > tmp) ? starts[j] - tmp : 32'd0;
         end
         2: begin
            periods[j] = frame - 1;
         end
         default: begin
         end
      endcase
      for (i = count - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = starts[i]; starts[i] = starts[j]; starts[j] = tmp;
         tmp = ends[i]; ends[i] = ends[j]; ends[j] = tmp;
         tmp = periods[i]; periods[i] = periods[j]; periods[j] = tmp;
      end
      for (i = 0; i < count; i++) send_command(OP_LOAD, starts[i], ends[i], periods[i]);
      if (close_it) send_command(OP_EVALUATE, $urandom, $urandom, $urandom);
   endtask

   // Unstructured commands: any times, ends before starts, occasional
   // evaluations. Nonzero periods are raised to the floor by OR-ing it in,
   // which keeps their low bits random.
   task automatic send_noise(int unsigned count);
      bit [31:0]      p;
      command_op_type op;
      repeat (count) begin
         op = ($urandom_range(0, 4) == 0) ? OP_EVALUATE : OP_LOAD;
         p = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
         if (p != 0) p = p | period_floor();
         send_command(op, $urandom, $urandom, p);
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned phase_end;
      int unsigned pick;
      bit [31:0]   level;

      book = new;
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= OP_LOAD;
      req_start_time <= '0;
      req_end_time <= '0;
      req_period <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part with a horizon of 100. The sender idles a little here.
      sender_idle_pct = 29;
      write_horizon(32'd100);
      // An evaluation of an empty set reports no conflict.
      send_command(OP_EVALUATE, '0, '0, '0);
      // A task starting exactly where the previous one ends is not a conflict.
      send_command(OP_LOAD, 32'd0, 32'd10, 32'd0);
      send_command(OP_LOAD, 32'd10, 32'd20, 32'd0);
      send_command(OP_EVALUATE, '0, '0, '0);
      // Starting one instant early is.
      send_command(OP_LOAD, 32'd0, 32'd10, 32'd0);
      send_command(OP_LOAD, 32'd9, 32'd20, 32'd0);
      send_command(OP_EVALUATE, '0, '0, '0);
      // An end before its start moves the current time backward.
      send_command(OP_LOAD, 32'd30, 32'd5, 32'd0);
      send_command(OP_LOAD, 32'd6, 32'd8, 32'd0);
      send_command(OP_EVALUATE, '1, '1, '1);
      // Two interleaved periodic tasks that never collide up to the horizon.
      send_command(OP_LOAD, 32'd10, 32'd20, 32'd20);
      send_command(OP_LOAD, 32'd0, 32'd10, 32'd20);
      send_command(OP_EVALUATE, '0, '0, '0);
      // Identical tasks collide with each other.
      send_command(OP_LOAD, 32'd0, 32'd5, 32'd10);
      send_command(OP_LOAD, 32'd0, 32'd5, 32'd10);
      send_command(OP_EVALUATE, '0, '0, '0);
      // Equal starts are ordered by the earlier end.
      send_command(OP_LOAD, 32'd0, 32'd8, 32'd0);
      send_command(OP_LOAD, 32'd0, 32'd4, 32'd0);
      send_command(OP_EVALUATE, '0, '0, '0);
      // A period of one walks the whole horizon, one pop per instant.
      send_command(OP_LOAD, 32'd0, 32'd0, 32'd1);
      send_command(OP_LOAD, '1, '1, '1);
      send_command(OP_EVALUATE, '0, '0, '0);

      // At the widest horizon, shifting a task that starts at the top of the
      // range again and again pushes its start time into the saturated value.
      settle();
      write_horizon('1);
      send_command(OP_LOAD, '1, '0, '1);
      send_command(OP_LOAD, '1, '1, '0);
      send_command(OP_EVALUATE, '0, '0, '0);

      // Random part. Each phase runs at its own horizon, the two extremes
      // among them; the sender idles often, then more often, then never.
      // Every other phase fills the heap to around its capacity.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: level = '1;
            1: level = '0;
            2: level = 32'd1000;
            3: level = $urandom;
            4: level = $urandom_range(0, 5000);
            default: level = 32'h8000_0000;
         endcase
         settle();
         write_horizon(level);
         sender_idle_pct = (phase < 2) ? 29 : ((phase < 4) ? 54 : 0);
         phase_end = items_sent + 333;
         if (phase % 2 == 1) begin
            case ($urandom_range(0, 3))
               0: load_schedule(HEAP_SLOTS - 1, 1'b1);
               1: load_schedule(HEAP_SLOTS, 1'b1);
               2: load_schedule(HEAP_SLOTS + 1, 1'b1);
               default: load_schedule(HEAP_SLOTS + 6, 1'b1);
            endcase
         end
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               load_schedule($urandom_range(1, (pick < 10) ? 40 : 10), $urandom_range(0, 9) != 0);
            end else if (pick < 92) begin
               send_noise($urandom_range(1, 6));
            end else begin
               send_command(OP_EVALUATE, $urandom, $urandom, $urandom);
            end
         end
         // Close the phase so no loaded tasks carry over to the next horizon.
         send_command(OP_EVALUATE, $urandom, $urandom, $urandom);
      end

      // Wait for the last verdicts and watch a few more cycles for strays.
      settle();
      $display("Sent %0d commands across %0d horizon settings; %0d evaluations, %0d with a",
               items_sent, PHASES + 2, book.evaluations, book.conflicts);
      $display("conflict and %0d with an overflow, walking %0d task pops in total.",
               book.overflows, book.pops);
      if (book.fault_count == 0) begin
         $display("periodic_task_overlap_check_test passed");
      end else begin
         $display("periodic_task_overlap_check_test failed");
      end
      $finish;
   end

endmodule

[periodic_task_overlap_check.f]
rtl/core/ptoc_pkg.sv
rtl/core/ptoc_cell.sv
rtl/core/periodic_task_overlap_check.sv
tb/sv/periodic_task_overlap_check_test.sv
